// File: rtl/gcoc_pkg.sv
// Shared types and constants for the gripper close/open controller.
`timescale 1ns / 1ps
`default_nettype none

package gcoc_pkg;

	localparam int LOAD_W      = 11;
	localparam int PERIOD_W    = 10;
	localparam int OUT_POS_W   = 12;
	localparam int CMD_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int NUM_BUTTONS = 4;

	localparam int BTN_START      = 0;
	localparam int BTN_STOP       = 1;
	localparam int BTN_TORQUE_ON  = 2;
	localparam int BTN_TORQUE_OFF = 3;

	localparam logic [OUT_POS_W-1:0] OUT_POS_MAX = 12'd4095;

	localparam int RST_CLOSE_STOP_POS  = 1000;
	localparam int RST_OPEN_STOP_POS   = 4095;
	localparam int RST_RAMP_STEP       = 40;
	localparam logic [LOAD_W-1:0]   RST_GRIP_LOAD_LIMIT = 11'd285;
	localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD     = 10'd50;
	localparam logic [PERIOD_W-1:0] RST_FEEDBACK_PERIOD = 10'd30;
	localparam logic [PERIOD_W-1:0] RST_DEBOUNCE_TIME   = 10'd30;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_OPENING = 2'd1,
		MODE_CLOSING = 2'd2,
		MODE_HOLD    = 2'd3
	} mode_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE       = 3'd0,
		CMD_CLOSE      = 3'd1,
		CMD_HOLD       = 3'd2,
		CMD_TORQUE_ON  = 3'd3,
		CMD_TORQUE_OFF = 3'd4,
		CMD_OPEN       = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLOSE_STOP_POS  = 3'd0,
		REG_OPEN_STOP_POS   = 3'd1,
		REG_RAMP_STEP       = 3'd2,
		REG_GRIP_LOAD_LIMIT = 3'd3,
		REG_STEP_PERIOD     = 3'd4,
		REG_FEEDBACK_PERIOD = 3'd5,
		REG_DEBOUNCE_TIME   = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic                    pos_write;
		logic [OUT_POS_W-1:0]    pos_value;
		logic                    torque_write;
		logic                    torque_enable;
		mode_t                   mode;
		logic [LOAD_W-1:0]       load_latched;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/gcoc_debounce.sv
// Debouncer for one active-low button, giving a press pulse per item.
`timescale 1ns / 1ps
`default_nettype none

module gcoc_debounce import gcoc_pkg::*; #(
	parameter int TIMER_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire logic                raw,
	input  wire logic [PERIOD_W-1:0] debounce_time,
	output logic                     press
);

	localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

	logic                  last_q;
	logic                  stable_q;
	logic [TIMER_BITS-1:0] hold_q;

	logic                  last_d;
	logic                  stable_d;
	logic [TIMER_BITS-1:0] hold_d;

	always_comb begin
		last_d   = last_q;
		stable_d = stable_q;
		press    = 1'b0;
		hold_d   = (hold_q == '1) ? hold_q : hold_q + 1'b1;
		if (raw != last_q) begin
			last_d = raw;
			hold_d = '0;
		end
		if ((CMP_W'(hold_d) >= CMP_W'(debounce_time)) && (stable_q != raw)) begin
			stable_d = raw;
			press    = !raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b1;
			stable_q <= 1'b1;
			hold_q   <= '0;
		end else if (advance) begin
			last_q   <= last_d;
			stable_q <= stable_d;
			hold_q   <= hold_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/gcoc_ctrl.sv
// Mode, ramp, load latch and timer state with the per-item update logic.
`timescale 1ns / 1ps
`default_nettype none

module gcoc_ctrl import gcoc_pkg::*; #(
	parameter int POS_BITS   = 12,
	parameter int TIMER_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire cmd_t                   cmd,
	input  wire logic [NUM_BUTTONS-1:0] press,
	input  wire logic                   load_valid,
	input  wire logic [LOAD_W-1:0]      load_sample,
	input  wire logic [POS_BITS-1:0]    close_stop_pos,
	input  wire logic [POS_BITS-1:0]    open_stop_pos,
	input  wire logic [POS_BITS-1:0]    ramp_step,
	input  wire logic [LOAD_W-1:0]      grip_load_limit,
	input  wire logic [PERIOD_W-1:0]    step_period,
	input  wire logic [PERIOD_W-1:0]    feedback_period,
	output result_t                     res
);

	localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;
	localparam int EXT_W = (POS_BITS > OUT_POS_W) ? POS_BITS : OUT_POS_W;

	mode_t                 mode_q, mode_d;
	logic [POS_BITS-1:0]   target_q, target_d;
	logic [LOAD_W-1:0]     held_q, held_d;
	logic [TIMER_BITS-1:0] fb_q, fb_d;
	logic [TIMER_BITS-1:0] st_q, st_d;

	logic                  tq_write;
	logic                  tq_value;
	logic                  pw;
	logic [POS_BITS:0]     sum;
	logic [POS_BITS-1:0]   diff;
	logic [EXT_W-1:0]      target_ext;

	always_comb begin
		mode_d   = mode_q;
		target_d = target_q;
		held_d   = held_q;
		fb_d     = (fb_q == '1) ? fb_q : fb_q + 1'b1;
		st_d     = (st_q == '1) ? st_q : st_q + 1'b1;
		tq_write = 1'b0;
		tq_value = 1'b0;
		pw       = 1'b0;
		sum      = {1'b0, target_q} + {1'b0, ramp_step};
		diff     = target_q - close_stop_pos;

		case (cmd)
			CMD_CLOSE: begin
				tq_write = 1'b1;
				tq_value = 1'b1;
				if (mode_d != MODE_CLOSING) begin
					mode_d = MODE_CLOSING;
					st_d   = '0;
				end
			end
			CMD_HOLD: mode_d = MODE_HOLD;
			CMD_TORQUE_ON: begin
				tq_write = 1'b1;
				tq_value = 1'b1;
			end
			CMD_TORQUE_OFF: begin
				tq_write = 1'b1;
				tq_value = 1'b0;
				mode_d   = MODE_IDLE;
			end
			CMD_OPEN: begin
				if (mode_d != MODE_OPENING) begin
					mode_d = MODE_OPENING;
					st_d   = '0;
				end
			end
			default: ;
		endcase

		if (press[BTN_START] && (mode_d != MODE_CLOSING)) begin
			tq_write = 1'b1;
			tq_value = 1'b1;
			mode_d   = MODE_CLOSING;
			st_d     = '0;
		end
		if (press[BTN_STOP]) begin
			mode_d = MODE_HOLD;
		end
		if (press[BTN_TORQUE_ON]) begin
			tq_write = 1'b1;
			tq_value = 1'b1;
		end
		if (press[BTN_TORQUE_OFF]) begin
			tq_write = 1'b1;
			tq_value = 1'b0;
			mode_d   = MODE_IDLE;
		end

		if (CMP_W'(fb_d) >= CMP_W'(feedback_period)) begin
			fb_d = '0;
			if (load_valid) begin
				held_d = load_sample;
			end
		end

		if (CMP_W'(st_d) >= CMP_W'(step_period)) begin
			st_d = '0;
			if (mode_d == MODE_OPENING) begin
				if (target_q < open_stop_pos) begin
					target_d = (sum < {1'b0, open_stop_pos}) ? sum[POS_BITS-1:0]
						: open_stop_pos;
					pw       = 1'b1;
				end else begin
					mode_d = MODE_IDLE;
				end
			end else if (mode_d == MODE_CLOSING) begin
				if (target_q > close_stop_pos) begin
					target_d = (diff > ramp_step) ? target_q - ramp_step : close_stop_pos;
					pw       = 1'b1;
				end
				if ($signed(held_d) >= $signed(grip_load_limit)) begin
					mode_d = MODE_HOLD;
				end
				if (target_d <= close_stop_pos) begin
					mode_d = MODE_HOLD;
				end
			end
		end

		target_ext        = EXT_W'(target_d);
		res.pos_write     = pw;
		res.pos_value     = (target_ext > EXT_W'(OUT_POS_MAX)) ? OUT_POS_MAX
			: target_ext[OUT_POS_W-1:0];
		res.torque_write  = tq_write;
		res.torque_enable = tq_value;
		res.mode          = mode_d;
		res.load_latched  = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			target_q <= '1;
			held_q   <= '0;
			fb_q     <= '0;
			st_q     <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			target_q <= target_d;
			held_q   <= held_d;
			fb_q     <= fb_d;
			st_q     <= st_d;
		end
	end

	a_torque_value_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		!res.torque_write |-> !res.torque_enable)
		else $error("torque enable set without a torque write");

	a_write_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.pos_write |-> (res.mode != MODE_IDLE))
		else $error("position write while going idle");

	a_open_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(res.pos_write && (res.mode == MODE_OPENING)) |-> (target_d <= open_stop_pos))
		else $error("opening ramp passed the open position");

	a_close_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(res.pos_write && (res.mode == MODE_CLOSING)) |-> (target_d > close_stop_pos))
		else $error("still closing after a step to or below the close limit");

endmodule

`default_nettype wire

// File: rtl/gripper_close_open_controller_core.sv
// Top level of the gripper close/open controller: handshakes, registers, datapath.
`timescale 1ns / 1ps
`default_nettype none

// One item is one control tick: a command, four raw active-low button levels and a
// load sample. The block accepts one item in every clock cycle unless a stalled output
// holds it back. An accepted item sits in the input register, where the debouncers and
// the mode and ramp logic work on it and update their state, and its result then waits
// in the output register, from which it is offered. The output register decouples the
// two sides: new items keep flowing while a result is waiting, and a stalled output
// stops the input only once both registers are full.
// Every item gives exactly one result. Configuration registers are written through
// their own channel, which is always ready, and are meant to change only while no
// item is in flight.

module gripper_close_open_controller_core import gcoc_pkg::*; #(
	parameter int POS_BITS   = 12,
	parameter int TIMER_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [CMD_W-1:0]      cmd,
	input  wire logic                  button_start,
	input  wire logic                  button_stop,
	input  wire logic                  button_torque_on,
	input  wire logic                  button_torque_off,
	input  wire logic                  load_valid,
	input  wire logic [LOAD_W-1:0]     load_sample,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       pos_write,
	output logic [OUT_POS_W-1:0]       pos_value,
	output logic                       torque_write,
	output logic                       torque_enable,
	output logic [1:0]                 mode,
	output logic [LOAD_W-1:0]          load_latched
);

	logic [POS_BITS-1:0]    close_stop_pos_q;
	logic [POS_BITS-1:0]    open_stop_pos_q;
	logic [POS_BITS-1:0]    ramp_step_q;
	logic [LOAD_W-1:0]      grip_load_limit_q;
	logic [PERIOD_W-1:0]    step_period_q;
	logic [PERIOD_W-1:0]    feedback_period_q;
	logic [PERIOD_W-1:0]    debounce_time_q;

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	logic [NUM_BUTTONS-1:0] raw_s1;
	logic                   load_valid_s1;
	logic [LOAD_W-1:0]      load_sample_s1;

	logic                   out_valid_q;
	result_t                res_q;
	result_t                res;
	logic                   advance;
	logic                   in_fire;
	logic [NUM_BUTTONS-1:0] press;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_stop_pos_q  <= POS_BITS'(RST_CLOSE_STOP_POS);
			open_stop_pos_q   <= POS_BITS'(RST_OPEN_STOP_POS);
			ramp_step_q       <= POS_BITS'(RST_RAMP_STEP);
			grip_load_limit_q <= RST_GRIP_LOAD_LIMIT;
			step_period_q     <= RST_STEP_PERIOD;
			feedback_period_q <= RST_FEEDBACK_PERIOD;
			debounce_time_q   <= RST_DEBOUNCE_TIME;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				REG_CLOSE_STOP_POS:  close_stop_pos_q  <= cfg_data[POS_BITS-1:0];
				REG_OPEN_STOP_POS:   open_stop_pos_q   <= cfg_data[POS_BITS-1:0];
				REG_RAMP_STEP:       ramp_step_q       <= cfg_data[POS_BITS-1:0];
				REG_GRIP_LOAD_LIMIT: grip_load_limit_q <= cfg_data[LOAD_W-1:0];
				REG_STEP_PERIOD:     step_period_q     <= cfg_data[PERIOD_W-1:0];
				REG_FEEDBACK_PERIOD: feedback_period_q <= cfg_data[PERIOD_W-1:0];
				REG_DEBOUNCE_TIME:   debounce_time_q   <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1         <= cmd_t'(cmd);
			raw_s1         <= {button_torque_off, button_torque_on, button_stop, button_start};
			load_valid_s1  <= load_valid;
			load_sample_s1 <= load_sample;
		end
	end

	genvar k;
	generate
		for (k = 0; k < NUM_BUTTONS; k++) begin : g_btn
			gcoc_debounce #(
				.TIMER_BITS(TIMER_BITS)
			) u_debounce (
				.clk          (clk),
				.arst_n       (arst_n),
				.advance      (advance),
				.raw          (raw_s1[k]),
				.debounce_time(debounce_time_q),
				.press        (press[k])
			);
		end
	endgenerate

	gcoc_ctrl #(
		.POS_BITS  (POS_BITS),
		.TIMER_BITS(TIMER_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.cmd            (cmd_s1),
		.press          (press),
		.load_valid     (load_valid_s1),
		.load_sample    (load_sample_s1),
		.close_stop_pos (close_stop_pos_q),
		.open_stop_pos  (open_stop_pos_q),
		.ramp_step      (ramp_step_q),
		.grip_load_limit(grip_load_limit_q),
		.step_period    (step_period_q),
		.feedback_period(feedback_period_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign pos_write     = res_q.pos_write;
	assign pos_value     = res_q.pos_value;
	assign torque_write  = res_q.torque_write;
	assign torque_enable = res_q.torque_enable;
	assign mode          = res_q.mode;
	assign load_latched  = res_q.load_latched;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stalled item dropped from the input register");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item produced no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
		else $error("waiting result overwritten");

endmodule

`default_nettype wire

// File: tb/gripper_close_open_controller_core_test.sv
// Testbench for the gripper close/open controller core: directed and random ticks.
`timescale 1ns / 1ps

module gripper_close_open_controller_core_test;
	import gcoc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_CODE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_CODE7 = 3'd7;
	localparam logic [LOAD_W-1:0] LOAD_MIN = 11'h400;
	localparam logic [LOAD_W-1:0] LOAD_MAX = 11'h3FF;
	localparam logic [3:0] ALL_RELEASED = 4'b1111;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct {
		bit                    write_reg;
		cfg_index_t            reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		logic [CMD_W-1:0]      cmd;
		logic [3:0]            buttons;
		logic                  load_valid;
		logic [LOAD_W-1:0]     load_sample;
		bit                    typed;
		result_t               typed_res;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] cmd = CMD_NONE;
	logic button_start = 1'b1;
	logic button_stop = 1'b1;
	logic button_torque_on = 1'b1;
	logic button_torque_off = 1'b1;
	logic load_valid = 1'b0;
	logic [LOAD_W-1:0] load_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic pos_write;
	logic [OUT_POS_W-1:0] pos_value;
	logic torque_write;
	logic torque_enable;
	logic [1:0] mode;
	logic [LOAD_W-1:0] load_latched;

	gripper_close_open_controller_core dut (.*);

	// Predictor configuration, starting from the reset values.
	logic [11:0] c_close_stop_pos = 12'(RST_CLOSE_STOP_POS);
	logic [11:0] c_open_stop_pos = 12'(RST_OPEN_STOP_POS);
	logic [11:0] c_ramp_step = 12'(RST_RAMP_STEP);
	logic [LOAD_W-1:0] c_grip_load_limit = RST_GRIP_LOAD_LIMIT;
	logic [PERIOD_W-1:0] c_step_period = RST_STEP_PERIOD;
	logic [PERIOD_W-1:0] c_feedback_period = RST_FEEDBACK_PERIOD;
	logic [PERIOD_W-1:0] c_debounce_time = RST_DEBOUNCE_TIME;

	// Predictor state, starting from the reset values.
	mode_t p_mode = MODE_IDLE;
	logic [11:0] p_target = OUT_POS_MAX;
	logic [LOAD_W-1:0] p_load = '0;
	logic [PERIOD_W-1:0] p_feedback_ticks = '0;
	logic [PERIOD_W-1:0] p_step_ticks = '0;
	logic [3:0] p_btn_last_raw = ALL_RELEASED;
	logic [3:0] p_btn_stable = ALL_RELEASED;
	logic [PERIOD_W-1:0] p_btn_hold [NUM_BUTTONS] = '{default: '0};

	result_t pending_results [$];
	int mismatch_count = 0;
	int unsigned cycle_count = 0;
	int sender_idle_pct = 0;
	int rx_stall_pct = 0;
	int out_hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [PERIOD_W-1:0] bump(input logic [PERIOD_W-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic void enter_mode(input mode_t m);
		if (p_mode != m) begin
			p_mode = m;
			p_step_ticks = '0;
		end
	endfunction

	function automatic result_t next_gripper_result(input logic [CMD_W-1:0] c,
			input logic [3:0] raw, input logic lv, input logic [LOAD_W-1:0] ls);
		result_t r;
		logic [3:0] press;
		logic tq_w;
		logic tq_v;
		logic pw;
		logic [12:0] sum;
		for (int k = 0; k < NUM_BUTTONS; k++)
			p_btn_hold[k] = bump(p_btn_hold[k]);
		p_feedback_ticks = bump(p_feedback_ticks);
		p_step_ticks = bump(p_step_ticks);
		tq_w = 1'b0;
		tq_v = 1'b0;
		pw = 1'b0;

		case (c)
			CMD_CLOSE: begin
				tq_w = 1'b1;
				tq_v = 1'b1;
				enter_mode(MODE_CLOSING);
			end
			CMD_HOLD: p_mode = MODE_HOLD;
			CMD_TORQUE_ON: begin
				tq_w = 1'b1;
				tq_v = 1'b1;
			end
			CMD_TORQUE_OFF: begin
				tq_w = 1'b1;
				tq_v = 1'b0;
				p_mode = MODE_IDLE;
			end
			CMD_OPEN: enter_mode(MODE_OPENING);
			default: ;
		endcase

		// Debouncing does not depend on the mode, so all presses are found first.
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			if (raw[k] != p_btn_last_raw[k]) begin
				p_btn_last_raw[k] = raw[k];
				p_btn_hold[k] = '0;
			end
			press[k] = 1'b0;
			if (p_btn_hold[k] >= c_debounce_time && p_btn_stable[k] != raw[k]) begin
				p_btn_stable[k] = raw[k];
				press[k] = !raw[k];
			end
		end
		if (press[BTN_START] && p_mode != MODE_CLOSING) begin
			tq_w = 1'b1;
			tq_v = 1'b1;
			enter_mode(MODE_CLOSING);
		end
		if (press[BTN_STOP])
			p_mode = MODE_HOLD;
		if (press[BTN_TORQUE_ON]) begin
			tq_w = 1'b1;
			tq_v = 1'b1;
		end
		if (press[BTN_TORQUE_OFF]) begin
			tq_w = 1'b1;
			tq_v = 1'b0;
			p_mode = MODE_IDLE;
		end

		if (p_feedback_ticks >= c_feedback_period) begin
			p_feedback_ticks = '0;
			if (lv)
				p_load = ls;
		end

		if (p_step_ticks >= c_step_period) begin
			p_step_ticks = '0;
			if (p_mode == MODE_OPENING) begin
				if (p_target < c_open_stop_pos) begin
					sum = {1'b0, p_target} + {1'b0, c_ramp_step};
					p_target = (sum < {1'b0, c_open_stop_pos}) ? sum[11:0] : c_open_stop_pos;
					pw = 1'b1;
				end else begin
					p_mode = MODE_IDLE;
				end
			end else if (p_mode == MODE_CLOSING) begin
				if (p_target > c_close_stop_pos) begin
					if (p_target - c_close_stop_pos > c_ramp_step)
						p_target = p_target - c_ramp_step;
					else
						p_target = c_close_stop_pos;
					pw = 1'b1;
				end
				if ($signed(p_load) >= $signed(c_grip_load_limit))
					p_mode = MODE_HOLD;
				if (p_target <= c_close_stop_pos)
					p_mode = MODE_HOLD;
			end
		end

		r.pos_write = pw;
		r.pos_value = p_target;
		r.torque_write = tq_w;
		r.torque_enable = tq_v;
		r.mode = p_mode;
		r.load_latched = p_load;
		return r;
	endfunction

	function automatic tick_row_t tick(input logic [CMD_W-1:0] c, input logic [3:0] b,
			input logic lv, input logic [LOAD_W-1:0] ls);
		tick_row_t row;
		row.write_reg = 1'b0;
		row.reg_idx = REG_CLOSE_STOP_POS;
		row.reg_data = '0;
		row.cmd = c;
		row.buttons = b;
		row.load_valid = lv;
		row.load_sample = ls;
		row.typed = 1'b0;
		row.typed_res = '0;
		return row;
	endfunction

	function automatic tick_row_t tick_known(input logic [CMD_W-1:0] c, input logic [3:0] b,
			input logic lv, input logic [LOAD_W-1:0] ls, input result_t r);
		tick_row_t row;
		row = tick(c, b, lv, ls);
		row.typed = 1'b1;
		row.typed_res = r;
		return row;
	endfunction

	function automatic tick_row_t reg_row(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
		tick_row_t row;
		row = tick(CMD_NONE, ALL_RELEASED, 1'b0, '0);
		row.write_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_data = d;
		return row;
	endfunction

	task automatic report_mismatch(input string why, input result_t e, input result_t a);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s at cycle %0d: expected pw=%0d pos=%0d tw=%0d te=%0d mode=%0d load=%0d,",
				why, cycle_count, e.pos_write, e.pos_value, e.torque_write, e.torque_enable,
				e.mode, $signed(e.load_latched),
				" got pw=%0d pos=%0d tw=%0d te=%0d mode=%0d load=%0d",
				a.pos_write, a.pos_value, a.torque_write, a.torque_enable, a.mode,
				$signed(a.load_latched));
	endtask

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_tick(input tick_row_t row);
		result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cmd <= row.cmd;
		button_start <= row.buttons[BTN_START];
		button_stop <= row.buttons[BTN_STOP];
		button_torque_on <= row.buttons[BTN_TORQUE_ON];
		button_torque_off <= row.buttons[BTN_TORQUE_OFF];
		load_valid <= row.load_valid;
		load_sample <= row.load_sample;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted = next_gripper_result(row.cmd, row.buttons, row.load_valid, row.load_sample);
		pending_results.push_back(row.typed ? row.typed_res : predicted);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d,
			input bit last);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CLOSE_STOP_POS: c_close_stop_pos = d[11:0];
			REG_OPEN_STOP_POS: c_open_stop_pos = d[11:0];
			REG_RAMP_STEP: c_ramp_step = d[11:0];
			REG_GRIP_LOAD_LIMIT: c_grip_load_limit = d[LOAD_W-1:0];
			REG_STEP_PERIOD: c_step_period = d[PERIOD_W-1:0];
			REG_FEEDBACK_PERIOD: c_feedback_period = d[PERIOD_W-1:0];
			REG_DEBOUNCE_TIME: c_debounce_time = d[PERIOD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (out_hold_left > 0) begin
			out_ready <= 1'b0;
			out_hold_left = out_hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		result_t observed;
		result_t wanted;
		if (arst_n && out_valid && out_ready) begin
			observed = {pos_write, pos_value, torque_write, torque_enable, mode, load_latched};
			if (pending_results.size() == 0) begin
				report_mismatch("Unexpected result", '0, observed);
			end else begin
				wanted = pending_results.pop_front();
				if (observed.pos_write !== wanted.pos_write ||
						observed.pos_value !== wanted.pos_value ||
						observed.torque_write !== wanted.torque_write ||
						observed.torque_enable !== wanted.torque_enable ||
						observed.mode !== wanted.mode ||
						observed.load_latched !== wanted.load_latched)
					report_mismatch("Wrong result", wanted, observed);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		tick_row_t directed_rows [$];
		tick_row_t row;
		logic [CFG_DATA_W-1:0] settings [7];
		logic [3:0] levels;
		bit prev_was_reg;
		bit last_reg;

		// A quiet tick, the torque and hold commands and the unused codes at the reset settings.
		directed_rows.push_back(tick_known(CMD_NONE, ALL_RELEASED, 1'b1, LOAD_MAX,
			result_t'{1'b0, OUT_POS_MAX, 1'b0, 1'b0, MODE_IDLE, 11'd0}));
		directed_rows.push_back(tick_known(CMD_TORQUE_ON, ALL_RELEASED, 1'b0, '0,
			result_t'{1'b0, OUT_POS_MAX, 1'b1, 1'b1, MODE_IDLE, 11'd0}));
		directed_rows.push_back(tick_known(CMD_TORQUE_OFF, ALL_RELEASED, 1'b0, '0,
			result_t'{1'b0, OUT_POS_MAX, 1'b1, 1'b0, MODE_IDLE, 11'd0}));
		directed_rows.push_back(tick_known(CMD_HOLD, ALL_RELEASED, 1'b0, '0,
			result_t'{1'b0, OUT_POS_MAX, 1'b0, 1'b0, MODE_HOLD, 11'd0}));
		directed_rows.push_back(tick_known(CMD_CODE6, ALL_RELEASED, 1'b0, '0,
			result_t'{1'b0, OUT_POS_MAX, 1'b0, 1'b0, MODE_HOLD, 11'd0}));
		directed_rows.push_back(tick_known(CMD_CODE7, ALL_RELEASED, 1'b0, '0,
			result_t'{1'b0, OUT_POS_MAX, 1'b0, 1'b0, MODE_HOLD, 11'd0}));
		// Fast timers and full-range steps.
		directed_rows.push_back(reg_row(REG_STEP_PERIOD, 16'd1));
		directed_rows.push_back(reg_row(REG_FEEDBACK_PERIOD, 16'd1));
		directed_rows.push_back(reg_row(REG_DEBOUNCE_TIME, 16'd0));
		directed_rows.push_back(reg_row(REG_RAMP_STEP, 16'd4095));
		directed_rows.push_back(reg_row(REG_CLOSE_STOP_POS, 16'd0));
		directed_rows.push_back(reg_row(REG_GRIP_LOAD_LIMIT, 16'(LOAD_MAX)));
		directed_rows.push_back(tick(CMD_CLOSE, ALL_RELEASED, 1'b1, LOAD_MIN));
		directed_rows.push_back(tick(CMD_NONE, ALL_RELEASED, 1'b0, LOAD_MAX));
		directed_rows.push_back(tick(CMD_OPEN, ALL_RELEASED, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, ALL_RELEASED, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, ALL_RELEASED, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, 4'b1110, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, 4'b1110, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, 4'b1101, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, 4'b1001, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, 4'b0001, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, ALL_RELEASED, 1'b0, '0));
		// A start press is ignored while a close command has already begun closing.
		directed_rows.push_back(tick(CMD_CLOSE, 4'b0000, 1'b1, LOAD_MAX));
		directed_rows.push_back(tick(CMD_NONE, ALL_RELEASED, 1'b0, '0));
		// The target already lies below the close limit, and the threshold is at its minimum.
		directed_rows.push_back(reg_row(REG_GRIP_LOAD_LIMIT, 16'(LOAD_MIN)));
		directed_rows.push_back(reg_row(REG_CLOSE_STOP_POS, 16'd4095));
		directed_rows.push_back(reg_row(REG_OPEN_STOP_POS, 16'd0));
		directed_rows.push_back(reg_row(REG_RAMP_STEP, 16'd1));
		directed_rows.push_back(tick(CMD_CLOSE, ALL_RELEASED, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, ALL_RELEASED, 1'b0, '0));
		directed_rows.push_back(tick(CMD_OPEN, ALL_RELEASED, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, ALL_RELEASED, 1'b0, '0));
		directed_rows.push_back(tick(CMD_NONE, ALL_RELEASED, 1'b0, '0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		prev_was_reg = 1'b0;
		for (int i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (row.write_reg) begin
				if (!prev_was_reg)
					wait_all_results();
				last_reg = (i + 1 == directed_rows.size()) || !directed_rows[i + 1].write_reg;
				write_register(row.reg_idx, row.reg_data, last_reg);
			end else begin
				send_tick(row);
			end
			prev_was_reg = row.write_reg;
		end

		levels = ALL_RELEASED;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: settings = '{16'd0, 16'd4095, 16'd1, 16'(LOAD_MAX), 16'd1, 16'd1, 16'd0};
				1: settings = '{16'(RST_CLOSE_STOP_POS), 16'(RST_OPEN_STOP_POS),
					16'(RST_RAMP_STEP), 16'(RST_GRIP_LOAD_LIMIT), 16'(RST_STEP_PERIOD),
					16'(RST_FEEDBACK_PERIOD), 16'(RST_DEBOUNCE_TIME)};
				2: settings = '{16'd4095, 16'd0, 16'd4095, 16'(LOAD_MIN), 16'd1023, 16'd1023,
					16'd1023};
				default: begin
					settings[REG_CLOSE_STOP_POS] = 16'($urandom_range(4095));
					settings[REG_OPEN_STOP_POS] = 16'($urandom_range(4095));
					settings[REG_RAMP_STEP] = 16'($urandom_range(700, 1));
					settings[REG_GRIP_LOAD_LIMIT] = 16'($urandom_range(2047));
					settings[REG_STEP_PERIOD] = 16'($urandom_range(6, 1));
					settings[REG_FEEDBACK_PERIOD] = 16'($urandom_range(8, 1));
					settings[REG_DEBOUNCE_TIME] = 16'($urandom_range(6));
				end
			endcase
			wait_all_results();
			for (int i = 0; i < 7; i++)
				write_register(cfg_index_t'(i), settings[i], i == 6);

			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 73;
					rx_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					rx_stall_pct = 73;
				end
				default: begin
					sender_idle_pct = 17;
					rx_stall_pct = 17;
				end
			endcase

			// A long receiver hold-off while items keep coming fills the block.
			if (phase == 0) begin
				@(posedge clk);
				out_hold_left = 150;
				@(negedge clk);
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 4 && n == ITEMS_PER_PHASE / 2)
					wait_all_results();
				for (int k = 0; k < NUM_BUTTONS; k++)
					if ($urandom_range(9) == 0)
						levels[k] = ~levels[k];
				row = tick(CMD_NONE, levels, 1'($urandom_range(1)), 11'($urandom_range(2047)));
				if ($urandom_range(99) >= 80)
					row.cmd = 3'($urandom_range(7));
				if ($urandom_range(1) == 0)
					row.load_sample = c_grip_load_limit + 11'($urandom_range(8)) - 11'd4;
				send_tick(row);
			end
		end

		wait_all_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
